>>> hw/rtl/fixed_point_alu_unit_assert.svh
// Assertion macros shared by the fixed-point ALU RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef FIXED_POINT_ALU_UNIT_ASSERT_SVH
`define FIXED_POINT_ALU_UNIT_ASSERT_SVH

// Check that cond holds at every edge outside reset.
`define FALU_ASSERT_NOW(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("%m: check failed");

// Check that post holds in the cycle after pre.
`define FALU_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("%m: check failed");

`endif

>>> hw/rtl/falu_pkg.sv
// Package for the fixed-point ALU: opcodes, cell modes and the control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package falu_pkg;

   typedef enum logic [3:0] {
      CMD_ADD        = 4'd0,
      CMD_SUB        = 4'd1,
      CMD_NEG        = 4'd2,
      CMD_MUL        = 4'd3,
      CMD_MUL_INT    = 4'd4,
      CMD_DIV        = 4'd5,
      CMD_DIV_INT    = 4'd6,
      CMD_DIV_TO_INT = 4'd7,
      CMD_FLOOR      = 4'd8,
      CMD_CEIL       = 4'd9,
      CMD_ROUND      = 4'd10,
      CMD_FRAC       = 4'd11,
      CMD_FROM_INT   = 4'd12
   } falu_cmd_type;

   // What the cells do with an item.
   typedef enum logic [1:0] {
      MODE_PASS = 2'd0,
      MODE_MUL  = 2'd1,
      MODE_DIV  = 2'd2
   } falu_mode_type;

   typedef struct packed {
      logic          valid;
      falu_mode_type mode;
      logic          fix;   // fixed-point multiply (shift product) when set
      logic          neg;   // negate the magnitude result
      logic          dz;    // zero divisor seen
   } falu_ctrl_type;

endpackage
`default_nettype wire

>>> hw/rtl/falu_front.sv
// Operand decode for the fixed-point ALU: sets up cell work or the direct result.
// Depends on falu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module falu_front #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  wire logic [3:0]          cmd,
   input  wire logic [31:0]         a,
   input  wire logic [31:0]         b,
   input  wire logic                valid,
   output falu_pkg::falu_ctrl_type  ctrl,
   output logic [W-1:0]             x,
   output logic [W+F-1:0]           y,
   output logic [2*W-1:0]           acc
);
   import falu_pkg::*;

   localparam int DW = W + F;

   logic [W-1:0]  a_w, b_w, ma, mb, flr, cl;
   logic [DW-1:0] a_x, a_sh;
   logic          sa, sb, fr_nz;

   // sign-extend from 32 bits, then wrap to the word
   generate
      if (W > 32) begin : g_wide
         assign a_w = {{(W-32){a[31]}}, a};
         assign b_w = {{(W-32){b[31]}}, b};
      end else begin : g_narrow
         assign a_w = a[W-1:0];
         assign b_w = b[W-1:0];
      end
   endgenerate

   assign sa    = a_w[W-1];
   assign sb    = b_w[W-1];
   assign ma    = sa ? -a_w : a_w;
   assign mb    = sb ? -b_w : b_w;
   assign a_x   = {{F{sa}}, a_w};
   assign a_sh  = $signed(a_x) >>> F;
   assign flr   = a_sh[W-1:0];
   assign fr_nz = |a_x[F-1:0];
   assign cl    = flr + W'(fr_nz);

   always_comb begin
      ctrl.valid = valid;
      ctrl.mode  = MODE_PASS;
      ctrl.fix   = 1'b0;
      ctrl.neg   = sa ^ sb;
      ctrl.dz    = 1'b0;
      x          = mb;
      y          = '0;
      acc        = '0;
      case (cmd)
         CMD_ADD:      acc[W-1:0] = a_w + b_w;
         CMD_SUB:      acc[W-1:0] = a_w - b_w;
         CMD_NEG:      acc[W-1:0] = -a_w;
         CMD_MUL, CMD_MUL_INT: begin
            ctrl.mode = MODE_MUL;
            ctrl.fix  = (cmd == CMD_MUL);
            x         = ma;
            y         = {{F{1'b0}}, mb};
         end
         CMD_DIV, CMD_DIV_INT, CMD_DIV_TO_INT: begin
            if (mb == '0) begin
               ctrl.dz = 1'b1;
            end else begin
               ctrl.mode = MODE_DIV;
               y = (cmd == CMD_DIV) ? {ma, {F{1'b0}}} : {{F{1'b0}}, ma};
            end
         end
         CMD_FLOOR:    acc[W-1:0] = flr;
         CMD_CEIL:     acc[W-1:0] = cl;
         CMD_ROUND:    acc[W-1:0] = a_x[F-1] ? cl : flr;
         CMD_FRAC: begin
            acc[W-1:0] = a_w & W'((DW'(1) << F) - DW'(1));
         end
         CMD_FROM_INT: acc[W-1:0] = a_w << F;
         default:      acc = '0;
      endcase
   end
endmodule
`default_nettype wire

>>> hw/rtl/falu_cell.sv
// One cell of the ALU chain: one shift-add multiply step, one restoring divide step, or a plain pass.
// Depends on falu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module falu_cell #(
   parameter int W = 32,
   parameter int F = 16,
   parameter int K = 0
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire falu_pkg::falu_ctrl_type ctrl_i,
   input  wire logic [W-1:0]            x_i,
   input  wire logic [W+F-1:0]          y_i,
   input  wire logic [2*W-1:0]          acc_i,
   output falu_pkg::falu_ctrl_type      ctrl_o,
   output logic [W-1:0]                 x_o,
   output logic [W+F-1:0]               y_o,
   output logic [2*W-1:0]               acc_o
);
   import falu_pkg::*;

   localparam int DW = W + F;
   localparam int AW = 2 * W;

   falu_ctrl_type ctrl_ff;
   logic [W-1:0]  x_ff;
   logic [DW-1:0] y_ff, y_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [W:0]    t, d;
   logic          ge;

   assign t  = {acc_i[W-1:0], y_i[DW-1]};
   assign d  = t - {1'b0, x_i};
   assign ge = (t >= {1'b0, x_i});

   always_comb begin
      y_in   = y_i;
      acc_in = acc_i;
      case (ctrl_i.mode)
         MODE_MUL: begin
            y_in = y_i >> 1;
            if (K < W && y_i[0]) acc_in = acc_i + (AW'(x_i) << K);
         end
         MODE_DIV: begin
            y_in   = {y_i[DW-2:0], ge};
            acc_in = AW'(ge ? d[W-1:0] : t[W-1:0]);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (en) begin
         ctrl_ff.valid <= ctrl_i.valid;
      end
      if (en) begin
         ctrl_ff.mode <= ctrl_i.mode;
         ctrl_ff.fix  <= ctrl_i.fix;
         ctrl_ff.neg  <= ctrl_i.neg;
         ctrl_ff.dz   <= ctrl_i.dz;
         x_ff         <= x_i;
         y_ff         <= y_in;
         acc_ff       <= acc_in;
      end
   end

   assign ctrl_o = ctrl_ff;
   assign x_o    = x_ff;
   assign y_o    = y_ff;
   assign acc_o  = acc_ff;
endmodule
`default_nettype wire

>>> hw/rtl/falu_back.sv
// Result assembly for the ALU: sign and scale of products and quotients; direct results pass, zero on a zero divisor.
// Depends on falu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module falu_back #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  wire falu_pkg::falu_ctrl_type ctrl,
   input  wire logic [W+F-1:0]          y,
   input  wire logic [2*W-1:0]          acc,
   output logic [W-1:0]                 result
);
   import falu_pkg::*;

   localparam int PW = 2 * W + F;

   logic [PW-1:0] p;
   logic [W-1:0]  q;

   assign p = ctrl.neg ? -PW'(acc) : PW'(acc);
   assign q = ctrl.neg ? -y[W-1:0] : y[W-1:0];

   always_comb begin
      case (ctrl.mode)
         MODE_MUL:  result = ctrl.fix ? p[F+W-1:F] : p[W-1:0];
         MODE_DIV:  result = q;
         default:   result = ctrl.dz ? '0 : acc[W-1:0];
      endcase
   end
endmodule
`default_nettype wire

>>> hw/rtl/fixed_point_alu_unit.sv
// Top level of the signed fixed-point ALU: decode, chain of cells, output register.
// Depends on falu_pkg, falu_front, falu_cell, falu_back and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Send one beat per operation on req_*: opcode in req_tuser, operands a and b
//   in req_tdata. One beat comes back on rsp_* per request, in request order:
//   result in rsp_tdata, zero-divisor flag in rsp_tuser.
//   Every beat walks the same chain of WORD_BITS + FRAC_BITS cells; a cell does
//   one shift-add multiply step, one restoring divide step or a plain pass, then
//   the output register holds the result. Every opcode takes the same path,
//   and one beat enters per cycle while no result waits unread.
//   The chain length is set by the divide: one quotient bit per cell across
//   the shifted dividend.
//   Reset clears the valid bits of all cells and the output register; data
//   in flight is dropped.
//   When the receiver stalls with a result waiting, the whole chain holds and
//   req_tready goes low; it advances again the cycle rsp_tready returns.
//   Results wrap to WORD_BITS; a zero divisor yields 0 with the flag set.
module fixed_point_alu_unit #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [31:0] a, [63:32] b
   input  wire logic [3:0]  req_tuser,   // [3:0] cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] result
   output logic             rsp_tuser    // [0] div_by_zero
);
   import falu_pkg::*;

   `include "fixed_point_alu_unit_assert.svh"

   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int DW = W + F;
   localparam int N  = DW;

   falu_ctrl_type ctrl_c [N+1];
   logic [W-1:0]      x_c   [N+1];
   logic [DW-1:0]     y_c   [N+1];
   logic [2*W-1:0]    acc_c [N+1];

   logic          en;
   logic [W-1:0]  res_w;
   logic [31:0]   res32;
   logic          out_valid_ff;
   logic [31:0]   out_data_ff;
   logic          out_dz_ff;

   // advance everything unless a result sits unread
   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;

   falu_front #(.W(W), .F(F)) u_front (
      .cmd   (req_tuser),
      .a     (req_tdata[31:0]),
      .b     (req_tdata[63:32]),
      .valid (req_tvalid),
      .ctrl  (ctrl_c[0]),
      .x     (x_c[0]),
      .y     (y_c[0]),
      .acc   (acc_c[0])
   );

   generate
      for (genvar k = 0; k < N; k++) begin : g_cell
         falu_cell #(.W(W), .F(F), .K(k)) u_cell (
            .clock  (clock),
            .reset  (reset),
            .en     (en),
            .ctrl_i (ctrl_c[k]),
            .x_i    (x_c[k]),
            .y_i    (y_c[k]),
            .acc_i  (acc_c[k]),
            .ctrl_o (ctrl_c[k+1]),
            .x_o    (x_c[k+1]),
            .y_o    (y_c[k+1]),
            .acc_o  (acc_c[k+1])
         );
      end
   endgenerate

   falu_back #(.W(W), .F(F)) u_back (
      .ctrl   (ctrl_c[N]),
      .y      (y_c[N]),
      .acc    (acc_c[N]),
      .result (res_w)
   );

   // present the word as 32 bits, sign-extended when narrower
   generate
      if (W >= 32) begin : g_out_wide
         assign res32 = res_w[31:0];
      end else begin : g_out_narrow
         assign res32 = {{(32-W){res_w[W-1]}}, res_w};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= ctrl_c[N].valid;
      end
      if (en) begin
         out_data_ff <= res32;
         out_dz_ff   <= ctrl_c[N].dz;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_dz_ff;

   `FALU_ASSERT_NOW(a_dz_zero, !(rsp_tvalid && rsp_tuser) || (rsp_tdata == 32'd0))
   `FALU_ASSERT_NOW(a_stall_blocks, !(rsp_tvalid && !rsp_tready) || !req_tready)
   `FALU_ASSERT_NEXT(a_last_cell_out, en && ctrl_c[N].valid, rsp_tvalid)

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking bench for fixed_point_alu_unit: directed corners, then random opcodes.
// Depends on falu_pkg and the fixed_point_alu_unit RTL; a scoreboard class predicts results.
`timescale 1ns / 1ps
`default_nettype none

class alu_scoreboard;
   typedef struct {
      logic [31:0] result;
      logic        dz;
   } alu_answer_type;

   alu_answer_type pending[$];
   int unsigned mismatches;

   function new();
      mismatches = 0;
   endfunction

   // Compute the expected answer of one accepted request beat.
   function void note_request(logic [3:0] cmd, logic [31:0] a, logic [31:0] b);
      alu_answer_type ans;
      longint sa, sb, prod, fl;
      logic [63:0] wide;
      sa = longint'($signed(a));
      sb = longint'($signed(b));
      ans.result = '0;
      ans.dz = 1'b0;
      fl = sa >>> 16;
      case (cmd)
         falu_pkg::CMD_ADD:      ans.result = a + b;
         falu_pkg::CMD_SUB:      ans.result = a - b;
         falu_pkg::CMD_NEG:      ans.result = -a;
         falu_pkg::CMD_MUL: begin
            prod = sa * sb;
            wide = prod >>> 16;
            ans.result = wide[31:0];
         end
         falu_pkg::CMD_MUL_INT:  ans.result = a * b;
         falu_pkg::CMD_DIV: begin
            if (b == 0) ans.dz = 1'b1;
            else begin
               wide = (sa * 65536) / sb;
               ans.result = wide[31:0];
            end
         end
         falu_pkg::CMD_DIV_INT, falu_pkg::CMD_DIV_TO_INT: begin
            if (b == 0) ans.dz = 1'b1;
            else begin
               wide = sa / sb;
               ans.result = wide[31:0];
            end
         end
         falu_pkg::CMD_FLOOR:    ans.result = fl[31:0];
         falu_pkg::CMD_CEIL:     ans.result = fl[31:0] + (a[15:0] != 0);
         falu_pkg::CMD_ROUND:
            ans.result = a[15] ? fl[31:0] + (a[15:0] != 0) : fl[31:0];
         falu_pkg::CMD_FRAC:     ans.result = {16'h0, a[15:0]};
         falu_pkg::CMD_FROM_INT: ans.result = {a[15:0], 16'h0};
         default:                ans.result = '0;
      endcase
      pending.push_back(ans);
   endfunction

   // Compare one response beat against the oldest pending answer.
   function void check_response(logic [31:0] result, logic dz);
      alu_answer_type ans;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response %h dz %b", result, dz);
         return;
      end
      ans = pending.pop_front();
      if (ans.result !== result || ans.dz !== dz) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected %h dz %b, got %h dz %b",
                     ans.result, ans.dz, result, dz);
      end
   endfunction
endclass

module tb_top;
   localparam int LATENCY   = 49;
   localparam int NUM_RAND  = 1800;
   localparam int WDOG_MAX  = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [31:0] a, [63:32] b
   logic [3:0]  req_tuser = '0;   // [3:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] result
   logic        rsp_tuser;        // [0] div_by_zero

   alu_scoreboard board = new();
   bit  long_stall_req = 1'b0;
   int  idle_cycles    = 0;

   always #1 clock = ~clock;

   fixed_point_alu_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // Sample both channels at the rising edge; feed the scoreboard.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_request(req_tuser, req_tdata[31:0], req_tdata[63:32]);
         if (rsp_tvalid && rsp_tready)
            board.check_response(rsp_tdata, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   // Watchdog: too long without any beat moving means the block hung.
   always @(posedge clock) begin
      if (idle_cycles >= WDOG_MAX) begin
         $display("** fixed_point_alu_unit: FAILED **");
         $finish;
      end
   end

   // Receiver: stall pattern of its own, plus one long hold-off on request.
   initial begin : receiver
      int mode;
      int k;
      @(negedge clock);
      forever begin
         if (long_stall_req) begin
            rsp_tready <= 1'b0;
            for (k = 0; k < 300; k++) @(negedge clock);
            long_stall_req = 1'b0;
         end
         mode = $urandom_range(0, 9);
         for (k = $urandom_range(1, 40); k > 0; k--) begin
            // hold ready high in some stretches, toggle in others
            rsp_tready <= (mode < 3) ? 1'b1 : ($urandom_range(0, 3) != 0);
            @(negedge clock);
         end
      end
   end

   // Drive one request beat and hold it until it is accepted.
   task automatic send_beat(logic [3:0] cmd, logic [31:0] a, logic [31:0] b);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid for a number of cycles.
   task automatic idle_gap(int n);
      req_tvalid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0;
         3: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, 16'($urandom_range(0, 65535))};
         4: return {16'($urandom_range(0, 65535)), 16'h0};
         default: return $urandom;
      endcase
   endfunction

   initial begin : sender
      logic [31:0] a, b;
      logic [3:0]  cmd;
      int sent;
      int burst;
      int w;
      bit stall_done;
      bit drain_done;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed corners: every opcode, zero divisor, exact integers,
      // half-way rounding, wrap at the extremes, undefined opcodes.
      send_beat(falu_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'h1);
      send_beat(falu_pkg::CMD_SUB, 32'h8000_0000, 32'h1);
      send_beat(falu_pkg::CMD_NEG, 32'h8000_0000, 32'hFFFF_FFFF);
      send_beat(falu_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000);
      send_beat(falu_pkg::CMD_MUL, 32'hFFFF_8000, 32'h0001_8000);
      send_beat(falu_pkg::CMD_MUL_INT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_beat(falu_pkg::CMD_DIV, 32'h0001_0000, 32'h0);
      send_beat(falu_pkg::CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      send_beat(falu_pkg::CMD_DIV, 32'hFFFF_0000, 32'h0003_0000);
      send_beat(falu_pkg::CMD_DIV_INT, 32'h8000_0000, 32'hFFFF_FFFF);
      send_beat(falu_pkg::CMD_DIV_INT, 32'h5, 32'h0);
      send_beat(falu_pkg::CMD_DIV_TO_INT, 32'hFFFF_FFF9, 32'h2);
      send_beat(falu_pkg::CMD_DIV_TO_INT, 32'h7, 32'h0);
      send_beat(falu_pkg::CMD_FLOOR, 32'hFFFF_8000, 32'hFFFF_FFFF);
      send_beat(falu_pkg::CMD_CEIL, 32'h0003_0000, 32'h0);
      send_beat(falu_pkg::CMD_CEIL, 32'h7FFF_0001, 32'h0);
      send_beat(falu_pkg::CMD_ROUND, 32'h0002_8000, 32'h0);
      send_beat(falu_pkg::CMD_ROUND, 32'hFFFF_7FFF, 32'h0);
      send_beat(falu_pkg::CMD_FRAC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(falu_pkg::CMD_FROM_INT, 32'h8000_8001, 32'h0);
      send_beat(4'd13, 32'h1234_5678, 32'h1);
      send_beat(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      idle_gap(3);

      // Random bursts; midway, fill the pipe against a long receiver stall
      // and then drain completely before resuming.
      sent = 0;
      stall_done = 1'b0;
      drain_done = 1'b0;
      while (sent < NUM_RAND) begin
         if (!stall_done && sent >= 600) begin
            long_stall_req = 1'b1;
            stall_done = 1'b1;
         end
         if (!drain_done && sent >= 1200) begin
            drain_done = 1'b1;
            req_tvalid <= 1'b0;
            while (board.pending.size() != 0) @(negedge clock);
         end
         burst = $urandom_range(1, 60);
         for (w = 0; w < burst && sent < NUM_RAND; w++) begin
            cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                               : 4'($urandom_range(0, 12));
            a = rand_operand();
            b = ($urandom_range(0, 15) == 0) ? 32'h0 : rand_operand();
            send_beat(cmd, a, b);
            sent++;
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
      end
      req_tvalid <= 1'b0;

      // Drain, then let the pipe settle before the verdict.
      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("** fixed_point_alu_unit: PASSED **");
      else
         $display("** fixed_point_alu_unit: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
